[rtl/per_bit_gap_histogram_unit_assert.svh]
// Assertion macros used by the gap histogram checker
`ifndef PER_BIT_GAP_HISTOGRAM_UNIT_ASSERT_SVH
`define PER_BIT_GAP_HISTOGRAM_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is held
`define PBGH_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gap histogram check failed");

// Next-cycle implication, disabled while reset is held
`define PBGH_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gap histogram check failed");

`endif

[rtl/pbgh_pkg.sv]
// Package: shared types and constants of the gap histogram unit
package pbgh_pkg;

    // Number of histogram bins and the saturating gap limit
    localparam int NUM_BINS    = 4;
    localparam int GAP_BITS    = 2;
    localparam logic [GAP_BITS-1:0] GAP_MAX = 2'd3;

    // Lanes summed by one leaf of the merge tree
    localparam int GROUP_LANES = 8;

    // Width of each count given on the output
    localparam int OUT_BITS    = 32;

    typedef logic [GAP_BITS-1:0] t_gap;

    // Control that travels with an item down the pipeline
    typedef struct packed {
        logic valid;
        logic last;
    } t_stage_ctl;

endpackage

[rtl/per_bit_gap_histogram_unit.sv]
// Top level: per-lane gap histogram over a stream of random words
//
// Input channel (i_valid / o_stall): one word per item on i_rand_word, bit i
// feeding lane i, with i_last_word marking the final word of a run. An item
// is taken at a rising edge with i_valid high and o_stall low.
// Output channel (o_valid / i_stall): one item per run carrying the four
// saturating bin counts o_gap0_count .. o_gap3_count.
// Throughput: one word per cycle while o_stall is low. Each lane updates
// its gap in the cycle the word is taken; the hit counts go through a
// two-level registered adder tree and then into the bin counters.
// Result path: a run's last word passes the lane hit register, both adder
// tree registers and the result register before its result shows on o_valid.
// Stall: words that end no run keep flowing while a result waits. Only when
// the held result is stalled and the next run's last word reaches the bin
// counters does o_stall rise and the whole pipeline hold.
// Reset: synchronous, active low; clears all gaps, bins and valid flags.
module per_bit_gap_histogram_unit
    import pbgh_pkg::*;
#(
    parameter int WORD_BITS  = 16,
    parameter int COUNT_BITS = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [WORD_BITS-1:0]  i_rand_word,
    input  logic                  i_last_word,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [OUT_BITS-1:0]   o_gap0_count,
    output logic [OUT_BITS-1:0]   o_gap1_count,
    output logic [OUT_BITS-1:0]   o_gap2_count,
    output logic [OUT_BITS-1:0]   o_gap3_count
);

    localparam int TOT_BITS = $clog2(WORD_BITS + 1);

    logic [NUM_BINS-1:0][WORD_BITS-1:0]  w_hits;
    logic [NUM_BINS-1:0][TOT_BITS-1:0]   w_incs;
    logic [NUM_BINS-1:0][OUT_BITS-1:0]   w_counts;
    t_stage_ctl                          w_hit_ctl;
    t_stage_ctl                          w_inc_ctl;
    logic                                w_hold;
    logic                                w_adv;
    logic                                w_take;

    // Hold everything only when a finished run cannot leave
    assign w_hold  = o_valid && i_stall && w_inc_ctl.valid && w_inc_ctl.last;
    assign w_adv   = !w_hold;
    assign w_take  = i_valid && w_adv;
    assign o_stall = w_hold;

    pbgh_lanes #(
        .WORD_BITS (WORD_BITS)
    ) u_lanes (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_take  (w_take),
        .i_word  (i_rand_word),
        .i_last  (i_last_word),
        .o_hits  (w_hits),
        .o_ctl   (w_hit_ctl)
    );

    pbgh_merge #(
        .WORD_BITS (WORD_BITS),
        .TOT_BITS  (TOT_BITS)
    ) u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_hits  (w_hits),
        .i_ctl   (w_hit_ctl),
        .o_incs  (w_incs),
        .o_ctl   (w_inc_ctl)
    );

    pbgh_accum #(
        .COUNT_BITS (COUNT_BITS),
        .TOT_BITS   (TOT_BITS)
    ) u_accum (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (w_adv),
        .i_incs   (w_incs),
        .i_ctl    (w_inc_ctl),
        .i_stall  (i_stall),
        .o_valid  (o_valid),
        .o_counts (w_counts)
    );

    // Fan the bin counts out to the result fields
    assign o_gap0_count = w_counts[0];
    assign o_gap1_count = w_counts[1];
    assign o_gap2_count = w_counts[2];
    assign o_gap3_count = w_counts[3];

endmodule

[rtl/pbgh_lanes.sv]
// Per-lane gap trackers and registered bin-hit vectors
module pbgh_lanes
    import pbgh_pkg::*;
#(
    parameter int WORD_BITS = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_adv,
    input  logic                                 i_take,
    input  logic [WORD_BITS-1:0]                 i_word,
    input  logic                                 i_last,
    output logic [NUM_BINS-1:0][WORD_BITS-1:0]   o_hits,
    output t_stage_ctl                           o_ctl
);

    t_gap [WORD_BITS-1:0]                r_gap;
    t_gap [WORD_BITS-1:0]                n_gap;
    logic [NUM_BINS-1:0][WORD_BITS-1:0]  n_hits;
    logic [NUM_BINS-1:0][WORD_BITS-1:0]  r_hits;
    t_stage_ctl                          r_ctl;

    // Mark the bin each lane's one lands in and advance each lane's gap
    always_comb begin
        for (int ln = 0; ln < WORD_BITS; ln++) begin
            for (int b = 0; b < NUM_BINS; b++) begin
                n_hits[b][ln] = i_word[ln] && (r_gap[ln] == GAP_BITS'(b));
            end
            if (i_word[ln]) begin
                n_gap[ln] = '0;
            end else if (r_gap[ln] == GAP_MAX) begin
                n_gap[ln] = GAP_MAX;
            end else begin
                n_gap[ln] = r_gap[ln] + t_gap'(1);
            end
        end
    end

    // Update gaps on each taken item; clear them after the last word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gap <= '0;
        end else if (i_take) begin
            r_gap <= i_last ? '0 : n_gap;
        end
    end

    // Stage register for the hit vectors
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_adv) begin
            r_ctl.valid <= i_take;
            r_ctl.last  <= i_take && i_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_hits <= n_hits;
        end
    end

    assign o_hits = r_hits;
    assign o_ctl  = r_ctl;

endmodule

[rtl/pbgh_merge.sv]
// Two-level registered adder tree counting hits per bin across lanes
module pbgh_merge
    import pbgh_pkg::*;
#(
    parameter int WORD_BITS = 16,
    parameter int TOT_BITS  = 5
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_adv,
    input  logic [NUM_BINS-1:0][WORD_BITS-1:0]   i_hits,
    input  t_stage_ctl                           i_ctl,
    output logic [NUM_BINS-1:0][TOT_BITS-1:0]    o_incs,
    output t_stage_ctl                           o_ctl
);

    localparam int NUM_GROUPS = (WORD_BITS + GROUP_LANES - 1) / GROUP_LANES;
    localparam int GRP_BITS   = $clog2(GROUP_LANES + 1);

    logic [NUM_BINS-1:0][NUM_GROUPS-1:0][GRP_BITS-1:0] n_grp;
    logic [NUM_BINS-1:0][NUM_GROUPS-1:0][GRP_BITS-1:0] r_grp;
    logic [NUM_BINS-1:0][TOT_BITS-1:0]                 n_tot;
    logic [NUM_BINS-1:0][TOT_BITS-1:0]                 r_tot;
    t_stage_ctl                                        r_ctl_grp;
    t_stage_ctl                                        r_ctl_tot;

    // Leaf level: count hits inside each group of lanes
    always_comb begin
        for (int b = 0; b < NUM_BINS; b++) begin
            for (int g = 0; g < NUM_GROUPS; g++) begin
                n_grp[b][g] = '0;
                for (int l = 0; l < GROUP_LANES; l++) begin
                    if (g * GROUP_LANES + l < WORD_BITS) begin
                        n_grp[b][g] = n_grp[b][g]
                            + GRP_BITS'(i_hits[b][g * GROUP_LANES + l]);
                    end
                end
            end
        end
    end

    // Root level: add the group counts of each bin
    always_comb begin
        for (int b = 0; b < NUM_BINS; b++) begin
            n_tot[b] = '0;
            for (int g = 0; g < NUM_GROUPS; g++) begin
                n_tot[b] = n_tot[b] + TOT_BITS'(r_grp[b][g]);
            end
        end
    end

    // Advance control through both tree levels
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl_grp <= '0;
            r_ctl_tot <= '0;
        end else if (i_adv) begin
            r_ctl_grp <= i_ctl;
            r_ctl_tot <= r_ctl_grp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_grp <= n_grp;
            r_tot <= n_tot;
        end
    end

    assign o_incs = r_tot;
    assign o_ctl  = r_ctl_tot;

endmodule

[rtl/pbgh_accum.sv]
// Saturating bin counters and the result register
module pbgh_accum
    import pbgh_pkg::*;
#(
    parameter int COUNT_BITS = 32,
    parameter int TOT_BITS   = 5
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_adv,
    input  logic [NUM_BINS-1:0][TOT_BITS-1:0]    i_incs,
    input  t_stage_ctl                           i_ctl,
    input  logic                                 i_stall,
    output logic                                 o_valid,
    output logic [NUM_BINS-1:0][OUT_BITS-1:0]    o_counts
);

    logic [NUM_BINS-1:0][COUNT_BITS-1:0]  r_bin;
    logic [NUM_BINS-1:0][COUNT_BITS-1:0]  n_bin;
    logic [NUM_BINS-1:0][COUNT_BITS:0]    w_sum;
    logic [NUM_BINS-1:0][OUT_BITS-1:0]    r_out;
    logic                                 r_out_valid;
    logic                                 w_load;

    // Add each bin's increment and stop at full scale
    always_comb begin
        for (int b = 0; b < NUM_BINS; b++) begin
            w_sum[b] = {1'b0, r_bin[b]} + (COUNT_BITS + 1)'(i_incs[b]);
            n_bin[b] = w_sum[b][COUNT_BITS] ? '1 : w_sum[b][COUNT_BITS-1:0];
        end
    end

    assign w_load = i_adv && i_ctl.valid && i_ctl.last;

    // Accumulate; clear all bins once the last word is counted
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bin <= '0;
        end else if (i_adv && i_ctl.valid) begin
            r_bin <= i_ctl.last ? '0 : n_bin;
        end
    end

    // Hold the result until the receiver takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            for (int b = 0; b < NUM_BINS; b++) begin
                r_out[b] <= OUT_BITS'(n_bin[b]);
            end
        end
    end

    assign o_valid  = r_out_valid;
    assign o_counts = r_out;

endmodule

[rtl/pbgh_checker.sv]
// Port-level checker for the gap histogram unit, with its bind
`include "per_bit_gap_histogram_unit_assert.svh"

module pbgh_checker
    import pbgh_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 o_stall,
    input  logic                 o_valid,
    input  logic                 i_stall,
    input  logic [OUT_BITS-1:0]  o_gap0_count,
    input  logic [OUT_BITS-1:0]  o_gap1_count,
    input  logic [OUT_BITS-1:0]  o_gap2_count,
    input  logic [OUT_BITS-1:0]  o_gap3_count
);

    // A stalled result stays put with its counts unchanged
    `PBGH_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall,
        o_valid && $stable(o_gap0_count) && $stable(o_gap1_count)
        && $stable(o_gap2_count) && $stable(o_gap3_count))

    // No result is shown in the cycle right after reset
    `PBGH_ASSERT_IMPL(a_reset_quiet, i_clk, i_rst_n, $past(!i_rst_n), !o_valid)

    // Input is held back only while a result is waiting on a stalled receiver
    `PBGH_ASSERT_IMPL(a_stall_cause, i_clk, i_rst_n, o_stall, o_valid && i_stall)

    // A held-back input with the receiver still stalled sees the result waiting next cycle
    `PBGH_ASSERT_NEXT(a_stall_out, i_clk, i_rst_n, o_stall && i_stall, o_valid)

endmodule

bind per_bit_gap_histogram_unit pbgh_checker u_pbgh_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_stall      (o_stall),
    .o_valid      (o_valid),
    .i_stall      (i_stall),
    .o_gap0_count (o_gap0_count),
    .o_gap1_count (o_gap1_count),
    .o_gap2_count (o_gap2_count),
    .o_gap3_count (o_gap3_count)
);
